/* rtl/pcaf_pkg.sv */
// ============================================================================
// pcaf_pkg
// Shared types and constants for the paced chunk audio FIFO: operation codes,
// configuration register indexes, reset values and the command and status
// groups between the controller and the datapath.
// ============================================================================
package pcaf_pkg;

    // Sizing defaults for the top level.
    localparam int DEPTH_DEFAULT = 1024;
    localparam int CHUNK_DEFAULT = 64;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DELAY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POP_INTERVAL = 1'b1;

    // Configuration reset values in milliseconds.
    localparam logic [CFG_W-1:0] FIRST_DELAY_RST  = 16'd80;
    localparam logic [CFG_W-1:0] POP_INTERVAL_RST = 16'd100;

    // Input operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_STREAM = 1'b1
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;
        logic clear;
        logic grant;
        logic refuse;
        logic stream;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rd_busy;
        logic grant_ok;
        logic last_issue;
    } dp_status_t;

endpackage

/* rtl/pcaf_ctrl.sv */
// ============================================================================
// pcaf_ctrl
// Controller of the paced chunk audio FIFO. Accepts input transactions,
// decodes the operation and sequences the read-out of a granted chunk.
// ============================================================================
module pcaf_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pcaf_pkg::OP_W-1:0]     opcode,
    input  pcaf_pkg::dp_status_t          status,
    output pcaf_pkg::ctrl_cmd_t           cmd
);
    import pcaf_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    opcode_t     op;

    assign op = opcode_t'(opcode);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // A pop needs the read stage free for its first result.
                s_tready = !status.rd_busy;
                if (s_tvalid && !status.rd_busy)
                begin
                    unique case (op)
                        OP_PUSH:  cmd.push  = 1'b1;
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_POP:
                        begin
                            if (status.grant_ok)
                            begin
                                cmd.grant  = 1'b1;
                                state_next = ST_STREAM;
                            end
                            else
                            begin
                                cmd.refuse = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_STREAM:
            begin
                cmd.stream = 1'b1;
                if (status.last_issue)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* rtl/pcaf_datapath.sv */
// ============================================================================
// pcaf_datapath
// Sample memory, FIFO pointers, fill count, pacing timer, configuration
// registers, the registered memory read stage and the output register.
// ============================================================================
module pcaf_datapath #(
    parameter int DEPTH = pcaf_pkg::DEPTH_DEFAULT,
    parameter int CHUNK = pcaf_pkg::CHUNK_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pcaf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcaf_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic [pcaf_pkg::SAMPLE_W-1:0]     sample_in,
    input  logic [pcaf_pkg::TIME_W-1:0]       now_ms,
    input  pcaf_pkg::ctrl_cmd_t               cmd,
    output pcaf_pkg::dp_status_t              status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pcaf_pkg::SAMPLE_W-1:0]     m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import pcaf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = $clog2(CHUNK + 1);

    // Sample memory.
    logic [SAMPLE_W-1:0] mem [DEPTH];

    // Control and pointer state.
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic               armed_reg, armed_next;
    logic [TIME_W-1:0]  next_time_reg, next_time_next;
    logic [CFG_W-1:0]   first_delay_reg, first_delay_next;
    logic [CFG_W-1:0]   pop_interval_reg, pop_interval_next;
    logic [CW-1:0]      rem_reg, rem_next;

    // Read stage and output register.
    logic               rd_valid_reg, rd_valid_next;
    logic               rd_granted_reg, rd_granted_next;
    logic               rd_last_reg, rd_last_next;
    logic [SAMPLE_W-1:0] rd_mem_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_granted_reg, out_granted_next;
    logic               out_last_reg, out_last_next;
    logic [SAMPLE_W-1:0] out_data_reg, out_data_next;

    logic [AW-1:0]      rd_ptr_inc, wr_ptr_inc;
    logic               full;
    logic               too_early;
    logic               enough;
    logic               out_load;
    logic               rd_free;
    logic               issue;
    logic [SAMPLE_W-1:0] rd_data;

    // Pointer wrap at the memory depth.
    assign rd_ptr_inc = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign full       = (fill_reg == FW'(DEPTH));

    // Pop decision: paced time reached and a whole chunk stored.
    assign too_early = armed_reg && (next_time_reg > now_ms);
    assign enough    = (fill_reg >= FW'(CHUNK));

    // Read stage moves into the output register when that is free or taken.
    assign out_load = rd_valid_reg && (!out_valid_reg || m_tready);
    assign rd_free  = !rd_valid_reg || out_load;
    assign issue    = cmd.stream && (rem_reg != '0) && rd_free;
    assign rd_data  = rd_granted_reg ? rd_mem_reg : '0;

    assign status.rd_busy    = rd_valid_reg;
    assign status.grant_ok   = !too_early && enough;
    assign status.last_issue = issue && (rem_reg == CW'(1));

    // Next values of pointers, count, pacing and configuration.
    always_comb
    begin
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        fill_next         = fill_reg;
        armed_next        = armed_reg;
        next_time_next    = next_time_reg;
        rem_next          = rem_reg;
        first_delay_next  = first_delay_reg;
        pop_interval_next = pop_interval_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST_DELAY:  first_delay_next  = cfg_wdata;
                CFG_POP_INTERVAL: pop_interval_next = cfg_wdata;
                default: ;
            endcase
        end

        priority if (cmd.clear)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            fill_next   = '0;
        end
        else if (cmd.push)
        begin
            // A full FIFO drops its oldest sample to make room.
            if (full)
            begin
                rd_ptr_next = rd_ptr_inc;
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
            end
            wr_ptr_next = wr_ptr_inc;
        end
        else if (cmd.grant)
        begin
            fill_next = fill_reg - FW'(CHUNK);
            rem_next  = CW'(CHUNK);
            if (!armed_reg)
            begin
                next_time_next = now_ms + TIME_W'(first_delay_reg);
                armed_next     = 1'b1;
            end
            else
            begin
                next_time_next = next_time_reg + TIME_W'(pop_interval_reg);
            end
        end
        else if (issue)
        begin
            rd_ptr_next = rd_ptr_inc;
            rem_next    = rem_reg - 1'b1;
        end
    end

    // Next values of the read stage and the output register.
    always_comb
    begin
        rd_valid_next    = rd_valid_reg;
        rd_granted_next  = rd_granted_reg;
        rd_last_next     = rd_last_reg;
        out_valid_next   = out_valid_reg;
        out_granted_next = out_granted_reg;
        out_last_next    = out_last_reg;
        out_data_next    = out_data_reg;

        priority if (cmd.refuse)
        begin
            rd_valid_next   = 1'b1;
            rd_granted_next = 1'b0;
            rd_last_next    = 1'b1;
        end
        else if (issue)
        begin
            rd_valid_next   = 1'b1;
            rd_granted_next = 1'b1;
            rd_last_next    = (rem_reg == CW'(1));
        end
        else if (out_load)
        begin
            rd_valid_next = 1'b0;
        end

        if (out_load)
        begin
            out_valid_next   = 1'b1;
            out_granted_next = rd_granted_reg;
            out_last_next    = rd_last_reg;
            out_data_next    = rd_data;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            fill_reg         <= '0;
            armed_reg        <= 1'b0;
            next_time_reg    <= '0;
            rem_reg          <= '0;
            first_delay_reg  <= FIRST_DELAY_RST;
            pop_interval_reg <= POP_INTERVAL_RST;
            rd_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            rd_ptr_reg       <= rd_ptr_next;
            wr_ptr_reg       <= wr_ptr_next;
            fill_reg         <= fill_next;
            armed_reg        <= armed_next;
            next_time_reg    <= next_time_next;
            rem_reg          <= rem_next;
            first_delay_reg  <= first_delay_next;
            pop_interval_reg <= pop_interval_next;
            rd_valid_reg     <= rd_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_granted_reg  <= rd_granted_next;
        rd_last_reg     <= rd_last_next;
        out_granted_reg <= out_granted_next;
        out_last_reg    <= out_last_next;
        out_data_reg    <= out_data_next;
    end

    // Sample memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_ptr_reg] <= sample_in;
        end
        if (issue)
        begin
            rd_mem_reg <= mem[rd_ptr_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_granted_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/paced_chunk_audio_fifo_unit.sv */
// ============================================================================
// paced_chunk_audio_fifo_unit
// Audio sample FIFO that keeps the newest samples and releases them in paced
// chunks of CHUNK samples on timed pop requests.
// ============================================================================
// Usage:
// The slave channel takes one operation per transaction: push one sample,
// pop request stamped with the current time in milliseconds, or clear.
// Pushes and clears give no result. A pop is
// refused (one result, granted flag low, last set) while the paced time has
// not been reached or fewer than CHUNK samples are stored. A granted pop
// streams CHUNK results, oldest first, with tlast on the final one.
// The read-out runs at one sample per cycle, while the receiver does not
// stall, through the memory read port; the first result passes through the
// read stage and the output register after the pop is accepted, and the next
// transaction is taken once the last sample has left the read stage.
// A finished result waits in the output register while the next transaction
// is taken. When the receiver stalls, the read-out pauses without loss.
// Reset empties the FIFO, disarms pacing and restores both time registers;
// the sample memory itself is not cleared. Configuration is written through
// cfg_we, cfg_index and cfg_wdata by the user while the block is idle;
// the block itself does not enforce this.
// ============================================================================
module paced_chunk_audio_fifo_unit #(
    parameter int DEPTH = pcaf_pkg::DEPTH_DEFAULT,
    parameter int CHUNK = pcaf_pkg::CHUNK_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pcaf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcaf_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [47:0]                       s_tdata,  // sample_in[15:0], now_ms[47:16]
    input  logic [pcaf_pkg::OP_W-1:0]         s_tuser,  // opcode[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pcaf_pkg::SAMPLE_W-1:0]     m_tdata,  // sample_out[15:0]
    output logic                              m_tuser,  // granted[0]
    output logic                              m_tlast
);
    import pcaf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Controller.
    pcaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    pcaf_datapath #(
        .DEPTH (DEPTH),
        .CHUNK (CHUNK)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample_in (s_tdata[SAMPLE_W-1:0]),
        .now_ms    (s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* rtl/pcaf_checker.sv */
// ============================================================================
// pcaf_checker
// Port-level checks for the paced chunk audio FIFO, bound to the top level.
// ============================================================================
module pcaf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [pcaf_pkg::OP_W-1:0]         s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pcaf_pkg::SAMPLE_W-1:0]     m_tdata,
    input logic                              m_tuser,
    input logic                              m_tlast
);
    import pcaf_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its sample.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result sample changed while stalled");

    // A refusal is a single, zero, final result.
    a_refuse_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("refused result not zero and final");

    // An accepted pop always drops tready right after it, blocking the next transaction.
    a_pop_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_POP) |=> !s_tready)
        else $error("transaction taken right after a pop");

endmodule

bind paced_chunk_audio_fifo_unit pcaf_checker u_pcaf_checker (.*);
